[src/lisl_pkg.sv]
// Package for the longest increasing subsequence length unit.
// Holds shared constants, the sequencer state type and the result struct.
// No dependencies.
package lisl_pkg;

   // Default tail table depth and the fixed field widths.
   localparam int DEF_MAX_LEN = 256;
   localparam int DATA_W      = 32;
   localparam int LEN_OUT_W   = 9;
   localparam int RSP_DATA_W  = 16;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Result handed from the sequencer to the response register.
   typedef struct packed {
      logic                 table_full;
      logic [LEN_OUT_W-1:0] longest_length;
   } result_type;

endpackage

[src/lisl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the tail table. No dependencies.
module lisl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lisl_ctrl.sv]
// Search and update sequencer: binary search over the tail table in RAM,
// then a single write-back and the length update. Depends on lisl_pkg and lisl_ram.
module lisl_ctrl
   import lisl_pkg::*;
#(
   parameter int MAX_LEN = DEF_MAX_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_first,
   input  logic [DATA_W-1:0] req_sample,
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);

   state_type          state_ff, state_in;
   logic [DATA_W-1:0]  key_ff, key_in;
   logic [LEN_W-1:0]   lo_ff, lo_in;
   logic [LEN_W-1:0]   hi_ff, hi_in;
   logic [LEN_W-1:0]   mid_ff, mid_in;
   logic               eq_ff, eq_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               ovf_ff, ovf_in;

   logic [LEN_W-1:0]   len_base;
   logic [LEN_W-1:0]   lo_n, hi_n, diff_n;
   logic               eq_n;
   logic               greater;
   logic               wr_en, rd_en;
   logic [DATA_W-1:0]  rd_data;
   logic [LEN_W+LEN_OUT_W-1:0] len_ext;

   // Tail table.
   lisl_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_LEN)
   ) u_tails (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(lo_ff[ADDR_W-1:0]),
      .wr_data(key_ff),
      .rd_en  (rd_en),
      .rd_addr(mid_in[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   // Control and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
      end
      key_ff <= key_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      eq_ff  <= eq_in;
   end

   // Search step: the read data of the previous probe narrows the range.
   always_comb begin
      greater = $signed(rd_data) > $signed(key_ff);
      if (greater) begin
         lo_n = lo_ff;
         hi_n = mid_ff;
         eq_n = eq_ff;
      end else begin
         lo_n = mid_ff + 1'b1;
         hi_n = hi_ff;
         eq_n = (rd_data == key_ff);
      end
      diff_n = hi_n - lo_n;
   end

   assign len_base = req_first ? '0 : len_ff;

   // Next state and outputs.
   always_comb begin
      state_in  = state_ff;
      key_in    = key_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      eq_in     = eq_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in = req_sample;
               len_in = len_base;
               ovf_in = req_first ? 1'b0 : ovf_ff;
               lo_in  = '0;
               hi_in  = len_base;
               eq_in  = 1'b0;
               mid_in = len_base >> 1;
               if (len_base != '0) begin
                  rd_en    = 1'b1;
                  state_in = ST_SEARCH;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_SEARCH: begin
            lo_in  = lo_n;
            hi_in  = hi_n;
            eq_in  = eq_n;
            mid_in = lo_n + (diff_n >> 1);
            if (lo_n < hi_n) begin
               rd_en = 1'b1;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // An equal tail just below the slot means the item changes nothing.
            if (!eq_ff) begin
               if (lo_ff < len_ff) begin
                  wr_en = 1'b1;
               end else if (len_ff < LEN_W'(MAX_LEN)) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Reported length is the count modulo 2**LEN_OUT_W.
   assign len_ext            = {{LEN_OUT_W{1'b0}}, len_ff};
   assign res.longest_length = len_ext[LEN_OUT_W-1:0];
   assign res.table_full     = ovf_ff;

endmodule

[src/longest_increasing_subsequence_length_unit.sv]
// Longest strictly increasing subsequence length unit, top level.
// Each request runs a binary search over the tail table, with at most ceil(log2(L+1))
// search probes for a table holding L tails, one probe per cycle through the single read
// port of the tail RAM. A new request is accepted only once the sequencer is idle again,
// after the previous result has been parked in the response register.
// Reset clears length, overflow flag and handshakes; the tail RAM is not cleared.
module longest_increasing_subsequence_length_unit
   import lisl_pkg::*;
#(
   parameter int MAX_LEN = DEF_MAX_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [31:0] sample_value
   input  logic                  req_tuser,   // [0] first_item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [8:0] longest_length, [9] table_full
);

   logic       res_valid, res_ready;
   result_type res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // Search and update sequencer with the tail table.
   lisl_ctrl #(
      .MAX_LEN(MAX_LEN)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_first (req_tuser),
      .req_sample(req_tdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Response register: frees the sequencer as soon as a result is parked.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - LEN_OUT_W - 1){1'b0}}, rsp_data_ff};

endmodule

[verif/tb_longest_increasing_subsequence_length_unit.sv]
// Testbench for longest_increasing_subsequence_length_unit: streams signed samples,
// predicts the running increasing-subsequence length and the table-full flag per request.
// Depends on lisl_pkg and the unit's RTL only.
module tb_longest_increasing_subsequence_length_unit
   import lisl_pkg::*;
;

   localparam int TAIL_DEPTH  = DEF_MAX_LEN;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 24;
   localparam int ITEM_TARGET = 2000;
   localparam int PHASE_LEN   = 150;

   typedef enum int {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE
   } idle_phase_type;

   // Tracks the tail table of the current sequence and queues the expected
   // length and overflow flag for every accepted request.
   class lis_length_tracker;
      logic signed [DATA_W-1:0] tails [TAIL_DEPTH];
      int                       run_len = 0;
      bit                       overflow = 1'b0;
      result_type               expected_results [$];
      int                       mismatches = 0;

      function void note_request(bit first, logic signed [DATA_W-1:0] value);
         int         lo;
         int         hi;
         int         mid;
         result_type want;
         if (first) begin
            run_len  = 0;
            overflow = 1'b0;
         end
         // Find the first tail strictly greater than the value.
         lo = 0;
         hi = run_len;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tails[mid] > value) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
         // An equal tail just below the slot blocks the update.
         if (!(lo > 0 && tails[lo-1] == value)) begin
            if (lo < run_len) begin
               tails[lo] = value;
            end else if (run_len < TAIL_DEPTH) begin
               tails[run_len] = value;
               run_len++;
            end else begin
               overflow = 1'b1;
            end
         end
         want.longest_length = LEN_OUT_W'(run_len);
         want.table_full     = overflow;
         expected_results = {expected_results, want};
      endfunction

      task report_mismatch(string field, int got, int want);
         $display("mismatch at %0t in %s: got %0d, expected %0d", $realtime, field, got, want);
         mismatches++;
      endtask

      task check_response(logic [RSP_DATA_W-1:0] data);
         result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", int'(data), -1);
            return;
         end
         want = expected_results.pop_front();
         if (data[LEN_OUT_W-1:0] != want.longest_length) begin
            report_mismatch("longest_length", int'(data[LEN_OUT_W-1:0]),
                            int'(want.longest_length));
         end
         if (data[LEN_OUT_W] != want.table_full) begin
            report_mismatch("table_full", int'(data[LEN_OUT_W]), int'(want.table_full));
         end
         if (data[RSP_DATA_W-1:LEN_OUT_W+1] != '0) begin
            report_mismatch("padding", int'(data[RSP_DATA_W-1:LEN_OUT_W+1]), 0);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata = '0;   // [31:0] sample_value
   logic                  req_tuser = 1'b0; // [0] first_item
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [8:0] longest_length, [9] table_full

   lis_length_tracker tracker = new;
   idle_phase_type    idle_phase = PH_STEADY;
   int                sent_count = 0;
   int                cycle_count = 0;

   longest_increasing_subsequence_length_unit #(
      .MAX_LEN(TAIL_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Run limit in case the unit hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int sender_idle_pct();
      case (idle_phase)
         PH_SENDER_IDLE: return 56;
         PH_BOTH_IDLE:   return 8;
         default:        return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_phase)
         PH_RECEIVER_STALL: return 56;
         PH_BOTH_IDLE:      return 8;
         default:           return 0;
      endcase
   endfunction

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct());
   end

   // Check every accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_response(rsp_tdata);
      end
   end

   // Offer one request, with random idle cycles first, and record it once accepted.
   task automatic send_request(input bit first, input logic signed [DATA_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= first;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      tracker.note_request(first, value);
      sent_count++;
      idle_phase = idle_phase_type'((sent_count / PHASE_LEN) % 4);
   endtask

   initial begin
      int                       seq_index;
      int                       long_runs;
      int                       kind;
      int                       seq_len;
      int                       k;
      bit                       first;
      longint                   chain;
      logic signed [DATA_W-1:0] value;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, equal values, restarts and a first request without a flag.
      send_request(1'b0, 32'sd0);
      send_request(1'b0, -32'sd2147483648);
      send_request(1'b0, -32'sd2147483648);
      send_request(1'b0, 32'sd2147483647);
      send_request(1'b0, 32'sd2147483647);
      send_request(1'b0, -32'sd1);
      send_request(1'b0, 32'sd0);
      send_request(1'b0, 32'sd5);
      send_request(1'b0, 32'sd3);
      send_request(1'b0, 32'sd3);
      send_request(1'b0, 32'sd4);
      send_request(1'b0, 32'sd2147483647);
      send_request(1'b1, 32'sd2147483647);
      send_request(1'b0, -32'sd2147483648);
      send_request(1'b0, -32'sd2147483647);
      send_request(1'b1, -32'sd2147483648);
      send_request(1'b1, 32'sd7);
      send_request(1'b0, 32'sd7);
      send_request(1'b0, 32'sd6);
      send_request(1'b0, 32'sd8);
      send_request(1'b0, 32'sd9);

      // Random sequences, each normally opened by a first-item flag.
      seq_index = 0;
      long_runs = 0;
      while (sent_count < ITEM_TARGET) begin
         first = ($urandom_range(19) != 0);
         if (long_runs < 3 && seq_index % 6 == 2) begin
            // Long mostly increasing run that overfills the tail table.
            long_runs++;
            chain = -64'sd2147483648 + $urandom_range(1000);
            seq_len = TAIL_DEPTH + $urandom_range(24, 4);
            first = 1'b1;
            k = 0;
            while (k < seq_len) begin
               if ($urandom_range(19) == 0) begin
                  value = $urandom;
               end else begin
                  chain += $urandom_range(1 << 20, 1);
                  value = chain[DATA_W-1:0];
                  k++;
               end
               send_request(first, value);
               first = 1'b0;
            end
         end else begin
            kind = $urandom_range(2);
            seq_len = $urandom_range(60, 1);
            chain = $signed($urandom_range(2000)) - 1000;
            for (k = 0; k < seq_len; k++) begin
               case (kind)
                  0: value = $signed($urandom_range(16)) - 8;
                  1: begin
                     // Rising with repeats and occasional dips.
                     if ($urandom_range(9) == 0) begin
                        value = $signed($urandom_range(4000)) - 2000;
                     end else begin
                        chain += $urandom_range(50);
                        value = chain[DATA_W-1:0];
                     end
                  end
                  default: value = $urandom;
               endcase
               send_request(first, value);
               first = 1'b0;
            end
         end
         seq_index++;
      end
      req_tvalid <= 1'b0;

      // Let the remaining responses drain, then allow for the pipeline latency.
      while (tracker.expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
